// ===== hdl/ncqi_pkg.sv =====
// Shared constants and types for the Newton cubic/quadratic interpolator.
// Used by ncqi_div and newton_cubic_quad_interp; depends on nothing else.
package ncqi_pkg;

  // Default datapath format: signed Q16.16
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Quotient bits resolved per divider pipeline stage
  localparam int unsigned DIV_BPS = 2;

  // Configuration port
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned GRID_WIDTH     = 31;
  localparam logic [GRID_WIDTH-1:0] GRID_RESET = 31'd65536;

  // Register index codes (word index taken from paddr[2])
  localparam logic REG_GRID_SPACING = 1'b0;

  // Divider status travelling with each quotient
  typedef struct packed {
    logic sat;   // quotient clipped to the data range
    logic zero;  // divisor was zero, quotient forced to zero
  } div_stat_t;

endpackage

// ===== hdl/ncqi_div.sv =====
// Pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated. Carries a sideband along. Depends on ncqi_pkg.
module ncqi_div import ncqi_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned SIDE_WIDTH = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  input  logic [SIDE_WIDTH-1:0] side_i,
  output logic                  vld_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output div_stat_t             stat_o,
  output logic [SIDE_WIDTH-1:0] side_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned N   = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned STG = (N + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned NP  = STG * DIV_BPS;
  localparam logic [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [NP-1:0] LIM_POS = (NP'(1) << (W-1)) - NP'(1);
  localparam logic [NP-1:0] LIM_NEG = NP'(1) << (W-1);

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // Stage 0 is the input register, stages 1..STG the iterations
  logic            vld_q  [0:STG];
  logic [W-1:0]    rem_q  [0:STG];
  logic [NP-1:0]   acc_q  [0:STG];
  logic [W-1:0]    den_q  [0:STG];
  logic            neg_q  [0:STG];
  logic            zero_q [0:STG];
  logic [SIDE_WIDTH-1:0] side_q [0:STG];

  // Capture magnitudes and signs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0]  <= NP'(mag_f(num_i)) << FRAC_BITS;
      rem_q[0]  <= '0;
      den_q[0]  <= mag_f(den_i);
      neg_q[0]  <= num_i[W-1] ^ den_i[W-1];
      zero_q[0] <= (den_i == '0);
      side_q[0] <= side_i;
    end
  end

  // Restoring division, DIV_BPS quotient bits per stage
  for (genvar s = 1; s <= STG; s++) begin : g_stage
    logic [W:0]    trial;
    logic [NP-1:0] acc_n;
    logic [W-1:0]  rem_n;

    always_comb begin
      acc_n = acc_q[s-1];
      rem_n = rem_q[s-1];
      trial = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {rem_n, acc_n[NP-1]};
        acc_n = {acc_n[NP-2:0], 1'b0};
        if (trial >= {1'b0, den_q[s-1]}) begin
          trial    = trial - {1'b0, den_q[s-1]};
          acc_n[0] = 1'b1;
        end
        rem_n = trial[W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s]  <= acc_n;
        rem_q[s]  <= rem_n;
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Apply sign, saturate, and force zero on a zero divisor
  logic [NP-1:0] quo_mag;
  logic          quo_sat;
  logic [W-1:0]  quo_res;

  always_comb begin
    quo_mag = acc_q[STG];
    quo_sat = quo_mag > (neg_q[STG] ? LIM_NEG : LIM_POS);
    if (zero_q[STG]) begin
      quo_res = '0;
    end else if (quo_sat) begin
      quo_res = neg_q[STG] ? DMIN : DMAX;
    end else begin
      quo_res = neg_q[STG] ? (~quo_mag[W-1:0] + 1'b1) : quo_mag[W-1:0];
    end
  end

  logic vld_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q[STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o       <= quo_res;
      stat_o.sat  <= quo_sat & ~zero_q[STG];
      stat_o.zero <= zero_q[STG];
      side_o      <= side_q[STG];
    end
  end

  assign vld_o = vld_out_q;

endmodule

// ===== hdl/newton_cubic_quad_interp.sv =====
// Newton divided-difference interpolator (cubic or quadratic), top level.
// Depends on ncqi_pkg and ncqi_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | in_valid_i / in_stall_o | op, stencil_x0..3, sample_v0..3, query
//  output   | out_valid_o/out_stall_i | interp_value, error_flag
//  config   | APB psel/penable/pready | grid_spacing at byte address 0
//
//  One transaction per cycle in steady state while in_stall_o is low. Each passes
//  through three chained divider pipelines, each of STG = ceil((DATA_WIDTH+FRAC_BITS)/
//  DIV_BPS) iteration stages; the default datapath format is Q16.16.
//  Reset clears all valid bits and loads grid_spacing with 1.0.
//  An output stall parks one result in a skid register; the input stalls only
//  while that register is full, and the whole pipeline holds with it.
module newton_cubic_quad_interp import ncqi_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [DATA_WIDTH-1:0]     stencil_x0_i,
  input  logic [DATA_WIDTH-1:0]     stencil_x1_i,
  input  logic [DATA_WIDTH-1:0]     stencil_x2_i,
  input  logic [DATA_WIDTH-1:0]     stencil_x3_i,
  input  logic [DATA_WIDTH-1:0]     sample_v0_i,
  input  logic [DATA_WIDTH-1:0]     sample_v1_i,
  input  logic [DATA_WIDTH-1:0]     sample_v2_i,
  input  logic [DATA_WIDTH-1:0]     sample_v3_i,
  input  logic [DATA_WIDTH-1:0]     query_x_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [DATA_WIDTH-1:0]     interp_value_o,
  output logic                      error_flag_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned PW  = 2 * DATA_WIDTH;
  localparam int unsigned SW  = 3 + 7 * DATA_WIDTH;
  localparam int unsigned SWN = 3 + 6 * DATA_WIDTH;
  localparam logic [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] LIM_POS = (PW'(1) << (W-1)) - PW'(1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W-1);

  // Saturating helpers: bit W of the result flags saturation
  function automatic logic [W:0] fx_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? DMIN : DMAX)};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] fx_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? DMIN : DMAX)};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // Rescale an unsigned product magnitude, then apply sign and saturate
  function automatic logic [W:0] fx_scale(input logic [PW-1:0] p, input logic neg);
    logic [PW-1:0] rs;
    rs = p >> FRAC_BITS;
    if (rs > (neg ? LIM_NEG : LIM_POS)) return {1'b1, (neg ? DMIN : DMAX)};
    return {1'b0, (neg ? (~rs[W-1:0] + 1'b1) : rs[W-1:0])};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration register
  logic [GRID_WIDTH-1:0] grid_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GRID_SPACING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_wr) begin
      grid_q <= pwdata[GRID_WIDTH-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_GRID_SPACING) ? APB_DATA_WIDTH'(grid_q) : '0;

  // ---------------------------------------------------------------------------
  // Global advance: hold everything while the skid register is occupied
  logic skid_vld_q;
  logic en;

  assign en         = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---------------------------------------------------------------------------
  // Stage A: differences, gaps and query offsets
  logic         h_big;
  logic [W-1:0] h_val;
  logic [W:0]   s_dv01, s_dv12, s_dv23, s_g21, s_g32, s_g20, s_g31, s_g30;
  logic [W:0]   s_qx0, s_qx1, s_qx2;

  assign h_big  = {33'b0, grid_q} > 64'(DMAX);
  assign h_val  = h_big ? DMAX : W'(grid_q);
  assign s_dv01 = fx_sub(sample_v1_i, sample_v0_i);
  assign s_dv12 = fx_sub(sample_v2_i, sample_v1_i);
  assign s_dv23 = fx_sub(sample_v3_i, sample_v2_i);
  assign s_g21  = fx_sub(stencil_x2_i, stencil_x1_i);
  assign s_g32  = fx_sub(stencil_x3_i, stencil_x2_i);
  assign s_g20  = fx_sub(stencil_x2_i, stencil_x0_i);
  assign s_g31  = fx_sub(stencil_x3_i, stencil_x1_i);
  assign s_g30  = fx_sub(stencil_x3_i, stencil_x0_i);
  assign s_qx0  = fx_sub(query_x_i, stencil_x0_i);
  assign s_qx1  = fx_sub(query_x_i, stencil_x1_i);
  assign s_qx2  = fx_sub(query_x_i, stencil_x2_i);

  logic         a_vld_q, a_op_q, a_flt_q;
  logic [W-1:0] a_h_q, a_v0_q, a_dv01_q, a_dv12_q, a_dv23_q, a_g21_q, a_g32_q;
  logic [W-1:0] a_g20_q, a_g31_q, a_g30_q, a_qx0_q, a_qx1_q, a_qx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q   <= op_i;
      a_h_q    <= h_val;
      a_v0_q   <= sample_v0_i;
      a_dv01_q <= s_dv01[W-1:0];
      a_dv12_q <= s_dv12[W-1:0];
      a_dv23_q <= s_dv23[W-1:0];
      a_g21_q  <= s_g21[W-1:0];
      a_g32_q  <= s_g32[W-1:0];
      a_g20_q  <= s_g20[W-1:0];
      a_g31_q  <= s_g31[W-1:0];
      a_g30_q  <= s_g30[W-1:0];
      a_qx0_q  <= s_qx0[W-1:0];
      a_qx1_q  <= s_qx1[W-1:0];
      a_qx2_q  <= s_qx2[W-1:0];
      a_flt_q  <= h_big | s_dv01[W] | s_dv12[W] | s_g21[W] | s_g20[W] | s_qx0[W] | s_qx1[W]
                | (~op_i & (s_dv23[W] | s_g32[W] | s_g31[W] | s_g30[W] | s_qx2[W]));
    end
  end

  // ---------------------------------------------------------------------------
  // First-order differences
  logic         s1_vld;
  logic [W-1:0] q12, q23, q34;
  div_stat_t    st12, st23, st34;
  logic [SW-1:0] s1_side;
  logic         s1_op, s1_flt, s1_spare;
  logic [W-1:0] s1_v0, s1_g20, s1_g31, s1_g30, s1_qx0, s1_qx1, s1_qx2;

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(SW)) u_div12 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q), .num_i(a_dv01_q), .den_i(a_h_q),
    .side_i({a_op_q, a_flt_q, 1'b0, a_v0_q, a_g20_q, a_g31_q, a_g30_q,
             a_qx0_q, a_qx1_q, a_qx2_q}),
    .vld_o(s1_vld), .quo_o(q12), .stat_o(st12), .side_o(s1_side)
  );

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(1)) u_div23 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q), .num_i(a_dv12_q), .den_i(a_g21_q),
    .side_i(1'b0), .vld_o(), .quo_o(q23), .stat_o(st23), .side_o()
  );

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(1)) u_div34 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(a_vld_q), .num_i(a_dv23_q), .den_i(a_g32_q),
    .side_i(1'b0), .vld_o(), .quo_o(q34), .stat_o(st34), .side_o()
  );

  assign {s1_op, s1_flt, s1_spare, s1_v0, s1_g20, s1_g31, s1_g30,
          s1_qx0, s1_qx1, s1_qx2} = s1_side;

  // Stage B: second-order numerators
  logic [W:0]   s_n123, s_n234;
  logic         b_vld_q, b_op_q, b_flt_q, b_zero_q;
  logic [W-1:0] b_n123_q, b_n234_q, b_v0_q, b_d12_q, b_g20_q, b_g31_q, b_g30_q;
  logic [W-1:0] b_qx0_q, b_qx1_q, b_qx2_q;

  assign s_n123 = fx_sub(q23, q12);
  assign s_n234 = fx_sub(q34, q23);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= s1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_op_q   <= s1_op;
      b_flt_q  <= s1_flt | s1_spare | st12.sat | st23.sat | s_n123[W]
                | (~s1_op & (st34.sat | s_n234[W]));
      b_zero_q <= st12.zero | st23.zero | (~s1_op & st34.zero);
      b_n123_q <= s_n123[W-1:0];
      b_n234_q <= s_n234[W-1:0];
      b_v0_q   <= s1_v0;
      b_d12_q  <= q12;
      b_g20_q  <= s1_g20;
      b_g31_q  <= s1_g31;
      b_g30_q  <= s1_g30;
      b_qx0_q  <= s1_qx0;
      b_qx1_q  <= s1_qx1;
      b_qx2_q  <= s1_qx2;
    end
  end

  // ---------------------------------------------------------------------------
  // Second-order differences
  logic         s2_vld;
  logic [W-1:0] q123, q234;
  div_stat_t    st123, st234;
  logic [SWN-1:0] s2_side;
  logic         s2_op, s2_flt, s2_zero;
  logic [W-1:0] s2_v0, s2_d12, s2_g30, s2_qx0, s2_qx1, s2_qx2;

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(SWN)) u_div123 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(b_vld_q), .num_i(b_n123_q), .den_i(b_g20_q),
    .side_i({b_op_q, b_flt_q, b_zero_q, b_v0_q, b_d12_q, b_g30_q,
             b_qx0_q, b_qx1_q, b_qx2_q}),
    .vld_o(s2_vld), .quo_o(q123), .stat_o(st123), .side_o(s2_side)
  );

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(1)) u_div234 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(b_vld_q), .num_i(b_n234_q), .den_i(b_g31_q),
    .side_i(1'b0), .vld_o(), .quo_o(q234), .stat_o(st234), .side_o()
  );

  assign {s2_op, s2_flt, s2_zero, s2_v0, s2_d12, s2_g30,
          s2_qx0, s2_qx1, s2_qx2} = s2_side;

  // Stage C: third-order numerator
  logic [W:0]   s_n1234;
  logic         c_vld_q, c_op_q, c_flt_q, c_zero_q;
  logic [W-1:0] c_n1234_q, c_g30_q, c_v0_q, c_d12_q, c_d123_q, c_qx0_q, c_qx1_q, c_qx2_q;

  assign s_n1234 = fx_sub(q234, q123);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= s2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_op_q    <= s2_op;
      c_flt_q   <= s2_flt | st123.sat | (~s2_op & (st234.sat | s_n1234[W]));
      c_zero_q  <= s2_zero | st123.zero | (~s2_op & st234.zero);
      c_n1234_q <= s_n1234[W-1:0];
      c_g30_q   <= s2_g30;
      c_v0_q    <= s2_v0;
      c_d12_q   <= s2_d12;
      c_d123_q  <= q123;
      c_qx0_q   <= s2_qx0;
      c_qx1_q   <= s2_qx1;
      c_qx2_q   <= s2_qx2;
    end
  end

  // ---------------------------------------------------------------------------
  // Third-order difference
  logic         s3_vld;
  logic [W-1:0] q1234;
  div_stat_t    st1234;
  logic [SWN-1:0] s3_side;
  logic         s3_op, s3_flt, s3_zero;
  logic [W-1:0] s3_v0, s3_d12, s3_d123, s3_qx0, s3_qx1, s3_qx2;

  ncqi_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(SWN)) u_div1234 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(c_vld_q), .num_i(c_n1234_q), .den_i(c_g30_q),
    .side_i({c_op_q, c_flt_q, c_zero_q, c_v0_q, c_d12_q, c_d123_q,
             c_qx0_q, c_qx1_q, c_qx2_q}),
    .vld_o(s3_vld), .quo_o(q1234), .stat_o(st1234), .side_o(s3_side)
  );

  assign {s3_op, s3_flt, s3_zero, s3_v0, s3_d12, s3_d123,
          s3_qx0, s3_qx1, s3_qx2} = s3_side;

  // ---------------------------------------------------------------------------
  // Stage D: (q - x2) * d1234 magnitude product
  logic          d_vld_q, d_op_q, d_flt_q, d_zero_q, d_neg_q;
  logic [PW-1:0] d_prod_q;
  logic [W-1:0]  d_d123_q, d_d12_q, d_v0_q, d_qx0_q, d_qx1_q;
  logic [W-1:0]  d_ma, d_mb;

  assign d_ma = mag_f(s3_qx2);
  assign d_mb = mag_f(q1234);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= s3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_op_q   <= s3_op;
      d_flt_q  <= s3_flt | (~s3_op & st1234.sat);
      d_zero_q <= s3_zero | (~s3_op & st1234.zero);
      d_prod_q <= PW'(d_ma) * PW'(d_mb);
      d_neg_q  <= s3_qx2[W-1] ^ q1234[W-1];
      d_d123_q <= s3_d123;
      d_d12_q  <= s3_d12;
      d_v0_q   <= s3_v0;
      d_qx0_q  <= s3_qx0;
      d_qx1_q  <= s3_qx1;
    end
  end

  // Stage E: innermost Horner step (cubic only)
  logic [W:0]   e_sc, e_ad;
  logic         e_vld_q, e_flt_q, e_zero_q;
  logic [W-1:0] e_acc_q, e_d12_q, e_v0_q, e_qx0_q, e_qx1_q;

  assign e_sc = fx_scale(d_prod_q, d_neg_q);
  assign e_ad = fx_add(d_d123_q, e_sc[W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_acc_q  <= d_op_q ? d_d123_q : e_ad[W-1:0];
      e_flt_q  <= d_flt_q | (~d_op_q & (e_sc[W] | e_ad[W]));
      e_zero_q <= d_zero_q;
      e_d12_q  <= d_d12_q;
      e_v0_q   <= d_v0_q;
      e_qx0_q  <= d_qx0_q;
      e_qx1_q  <= d_qx1_q;
    end
  end

  // Stage F: (q - x1) * acc
  logic          f_vld_q, f_flt_q, f_zero_q, f_neg_q;
  logic [PW-1:0] f_prod_q;
  logic [W-1:0]  f_d12_q, f_v0_q, f_qx0_q;
  logic [W-1:0]  f_ma, f_mb;

  assign f_ma = mag_f(e_qx1_q);
  assign f_mb = mag_f(e_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_prod_q <= PW'(f_ma) * PW'(f_mb);
      f_neg_q  <= e_qx1_q[W-1] ^ e_acc_q[W-1];
      f_flt_q  <= e_flt_q;
      f_zero_q <= e_zero_q;
      f_d12_q  <= e_d12_q;
      f_v0_q   <= e_v0_q;
      f_qx0_q  <= e_qx0_q;
    end
  end

  // Stage G: acc = d12 + scaled product
  logic [W:0]   g_sc, g_ad;
  logic         g_vld_q, g_flt_q, g_zero_q;
  logic [W-1:0] g_acc_q, g_v0_q, g_qx0_q;

  assign g_sc = fx_scale(f_prod_q, f_neg_q);
  assign g_ad = fx_add(f_d12_q, g_sc[W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_acc_q  <= g_ad[W-1:0];
      g_flt_q  <= f_flt_q | g_sc[W] | g_ad[W];
      g_zero_q <= f_zero_q;
      g_v0_q   <= f_v0_q;
      g_qx0_q  <= f_qx0_q;
    end
  end

  // Stage H: (q - x0) * acc
  logic          h_vld_q, h_flt_q, h_zero_q, h_neg_q;
  logic [PW-1:0] h_prod_q;
  logic [W-1:0]  h_v0_q;
  logic [W-1:0]  h_ma, h_mb;

  assign h_ma = mag_f(g_qx0_q);
  assign h_mb = mag_f(g_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_prod_q <= PW'(h_ma) * PW'(h_mb);
      h_neg_q  <= g_qx0_q[W-1] ^ g_acc_q[W-1];
      h_flt_q  <= g_flt_q;
      h_zero_q <= g_zero_q;
      h_v0_q   <= g_v0_q;
    end
  end

  // Stage I: final add; a zero gap overrides with the positive limit
  logic [W:0]   i_sc, i_ad;
  logic         i_vld_q, i_flt_q;
  logic [W-1:0] i_val_q;

  assign i_sc = fx_scale(h_prod_q, h_neg_q);
  assign i_ad = fx_add(h_v0_q, i_sc[W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_vld_q <= 1'b0;
    end else if (en) begin
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_val_q <= h_zero_q ? DMAX : i_ad[W-1:0];
      i_flt_q <= h_flt_q | h_zero_q | i_sc[W] | i_ad[W];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid: park a result when the output is stalled
  logic         out_vld_q, out_flt_q, skid_flt_q;
  logic [W-1:0] out_val_q, skid_val_q;
  logic         out_take, out_free, pipe_out;

  assign out_take = out_vld_q & ~out_stall_i;
  assign out_free = ~out_vld_q | out_take;
  assign pipe_out = en & i_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (pipe_out) begin
      if (out_free) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) begin
        out_val_q <= skid_val_q;
        out_flt_q <= skid_flt_q;
      end
    end else if (pipe_out) begin
      if (out_free) begin
        out_val_q <= i_val_q;
        out_flt_q <= i_flt_q;
      end else begin
        skid_val_q <= i_val_q;
        skid_flt_q <= i_flt_q;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign interp_value_o = out_val_q;
  assign error_flag_o   = out_flt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid register filled without an output stall");

  a_grid_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> grid_q == $past(pwdata[GRID_WIDTH-1:0]))
    else $error("grid_spacing write was not taken");

  a_zero_gap_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && h_vld_q && h_zero_q) |=> (i_flt_q && i_val_q == DMAX))
    else $error("zero gap did not force the saturated result");

endmodule
